// File: rtl/core/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// command, status and state codes shared by the lifo stack modules
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int unsigned CAP_W = 9;
  localparam int unsigned POS_W = 9;
  localparam int unsigned VAL_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_TOP  = 2'd3
  } lsp_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_BADPOS    = 2'd3
  } lsp_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } lsp_state_t;

  typedef struct packed {
    logic issue;
    logic cfg_wr;
  } lsp_ctrl_t;

endpackage

// File: rtl/core/lsp_ifs.sv
// ----------------------------------------------------------------------------
// lsp channel interfaces
// valid/ready channels for commands, results and the capacity register
// ----------------------------------------------------------------------------
interface lsp_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic signed [lsp_pkg::VAL_W-1:0]    push_value;
  logic [lsp_pkg::POS_W-1:0]           position;

  modport source (output valid, cmd, push_value, position, input ready);
  modport sink   (input valid, cmd, push_value, position, output ready);
endinterface

interface lsp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lsp_pkg::VAL_W-1:0]    read_value;
  logic [1:0]                          status;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, read_value, status, is_empty, is_full, input ready);
  modport sink   (input valid, read_value, status, is_empty, is_full, output ready);
endinterface

interface lsp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lsp_pkg::CAP_W-1:0]           capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// File: rtl/core/lifo_stack_with_peek_top.sv
// result is valid in the cycle after the command word is accepted
// throughput: one command word per cycle while results are taken at once;
//   a stalled result holds the next command in the input handshake
// the single-port stack memory has a registered read, which sets when the result is valid
// reset clears the fill pointer and sets capacity to 256; memory is not cleared
// ----------------------------------------------------------------------------
// lifo_stack_with_peek_top
// lifo stack with push, pop, peek at depth and top, configurable capacity
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_top #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lsp_in_if.sink     in_ch,
  lsp_out_if.source  out_ch,
  lsp_cfg_if.sink    cfg_ch
);

  lsp_pkg::lsp_ctrl_t ctrl;

  lsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .ctrl      (ctrl)
  );

  lsp_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .cmd          (in_ch.cmd),
    .push_value   (in_ch.push_value),
    .position     (in_ch.position),
    .cfg_capacity (cfg_ch.capacity),
    .read_value   (out_ch.read_value),
    .status       (out_ch.status),
    .is_empty     (out_ch.is_empty),
    .is_full      (out_ch.is_full)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> out_ch.valid)
    else $error("accepted word produced no result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("command accepted while result stalled");

  a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != lsp_pkg::STAT_OK) |-> (out_ch.read_value == '1))
    else $error("failed command returned a value");

  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_empty |-> !out_ch.is_full)
    else $error("empty and full flagged together");

endmodule

// File: rtl/core/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// lsp_ctrl
// handshake controller: issues commands to the datapath, holds the result
// ----------------------------------------------------------------------------
module lsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  output lsp_pkg::lsp_ctrl_t  ctrl
);

  lsp_pkg::lsp_state_t state_r, state_nxt;
  logic                accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsp_pkg::ST_IDLE: begin
        if (accept) state_nxt = lsp_pkg::ST_RESP;
      end
      lsp_pkg::ST_RESP: begin
        if (out_ready && !accept) state_nxt = lsp_pkg::ST_IDLE;
      end
      default: state_nxt = lsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      lsp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lsp_pkg::ST_RESP: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cfg_ready   = 1'b1;
    ctrl.issue  = in_valid && in_ready;
    ctrl.cfg_wr = cfg_valid;
  end

endmodule

// File: rtl/core/lsp_dpath.sv
// ----------------------------------------------------------------------------
// lsp_dpath
// stack memory, fill pointer, capacity register and result registers
// ----------------------------------------------------------------------------
module lsp_dpath #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lsp_pkg::lsp_ctrl_t                  ctrl,
  input  logic [1:0]                          cmd,
  input  logic signed [lsp_pkg::VAL_W-1:0]    push_value,
  input  logic [lsp_pkg::POS_W-1:0]           position,
  input  logic [lsp_pkg::CAP_W-1:0]           cfg_capacity,
  output logic signed [lsp_pkg::VAL_W-1:0]    read_value,
  output logic [1:0]                          status,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (FW > lsp_pkg::CAP_W) ? FW : lsp_pkg::CAP_W;

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_q_r;

  logic [FW-1:0]             fill_r, fill_nxt;
  logic [lsp_pkg::CAP_W-1:0] cap_r;
  lsp_pkg::lsp_status_t      status_r, status_nxt;
  logic                      ok_r, ok_nxt;
  logic                      empty_r, full_r;

  logic [CW-1:0] cap_eff, fill_w, pos_w, addr_w;
  logic          wr_en, rd_en;

  always_comb begin
    cap_eff = CW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (cap_eff > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end
  end

  assign fill_w = CW'(fill_r);
  assign pos_w  = CW'(position);

  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = lsp_pkg::STAT_OK;
    ok_nxt     = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    addr_w     = fill_w - CW'(1);
    unique case (lsp_pkg::lsp_cmd_t'(cmd))
      lsp_pkg::CMD_PUSH: begin
        addr_w = fill_w;
        if (fill_w >= cap_eff) begin
          status_nxt = lsp_pkg::STAT_OVERFLOW;
        end else begin
          wr_en    = ctrl.issue;
          fill_nxt = fill_r + FW'(1);
        end
      end
      lsp_pkg::CMD_POP: begin
        if (fill_r == '0) begin
          status_nxt = lsp_pkg::STAT_UNDERFLOW;
        end else begin
          rd_en    = ctrl.issue;
          ok_nxt   = 1'b1;
          fill_nxt = fill_r - FW'(1);
        end
      end
      lsp_pkg::CMD_PEEK: begin
        addr_w = fill_w - pos_w;
        if (position == '0 || pos_w > fill_w) begin
          status_nxt = lsp_pkg::STAT_BADPOS;
        end else begin
          rd_en  = ctrl.issue;
          ok_nxt = 1'b1;
        end
      end
      lsp_pkg::CMD_TOP: begin
        if (fill_r == '0) begin
          status_nxt = lsp_pkg::STAT_UNDERFLOW;
        end else begin
          rd_en  = ctrl.issue;
          ok_nxt = 1'b1;
        end
      end
      default: status_nxt = lsp_pkg::STAT_OK;
    endcase
  end

  // stack storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_w[AW-1:0]] <= DATA_WIDTH'(push_value);
    if (rd_en) mem_q_r <= mem[addr_w[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cap_r  <= lsp_pkg::CAP_RESET;
    end else begin
      if (ctrl.issue)  fill_r <= fill_nxt;
      if (ctrl.cfg_wr) cap_r  <= cfg_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      status_r <= status_nxt;
      ok_r     <= ok_nxt;
      empty_r  <= (fill_nxt == '0);
      full_r   <= (CW'(fill_nxt) >= cap_eff);
    end
  end

  assign read_value = ok_r ? lsp_pkg::VAL_W'(mem_q_r) : '1;
  assign status     = status_r;
  assign is_empty   = empty_r;
  assign is_full    = full_r;

endmodule
